/* rtl/core/glcc_pkg.sv */
// Shared types and constants of the GPS lap line crossing counter.
package glcc_pkg;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int HDG_W    = 16;
	localparam int SCALE_W  = 17;
	localparam int TRIG_W   = 16;
	localparam int TOL_W    = 16;
	localparam int LAPS_W   = 16;
	localparam int OUT_POS_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DLON_W   = LON_W + 1;
	localparam int DLAT_W   = LAT_W + 1;
	localparam int MUL_A_W  = 35;
	localparam int MUL_B_W  = 18;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int SCALE_SH = 16;
	localparam int TRIG_SH  = 14;
	localparam int ROT_W    = MUL_P_W - TRIG_SH;

	localparam logic [HDG_W-1:0] HEADING_MOD = 16'd36000;
	localparam logic [HDG_W-1:0] HEADING_TOL = 16'd3000;

	localparam logic [CFG_IDX_W-1:0] CFG_HOME_LAT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_LON  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_HDG  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COS_HDG   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN_HDG   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL   = 3'd7;

	localparam logic [SCALE_W-1:0] SCALE_RST = 17'd72945;
	localparam logic [TRIG_W-1:0]  COS_RST   = 16'd16384;
	localparam logic [TOL_W-1:0]   TOL_RST   = 16'd800;

	typedef enum logic [1:0] {
		MAC_NONE = 2'd0,
		MAC_LOAD = 2'd1,
		MAC_ADD  = 2'd2,
		MAC_SUB  = 2'd3
	} mac_op_t;

	typedef struct packed {
		logic [LAPS_W-1:0] lap_count;
		logic              lap_done;
		logic              near_home;
	} lap_res_t;

	function automatic logic [HDG_W-1:0] heading_mod(input logic [HDG_W-1:0] h);
		return (h >= HEADING_MOD) ? h - HEADING_MOD : h;
	endfunction

endpackage

/* rtl/core/glcc_if.sv */
// Valid/ready channel interfaces for GPS fixes and lap results.
interface glcc_fix_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [glcc_pkg::LAT_W-1:0]     latitude;
	logic signed [glcc_pkg::LON_W-1:0]     longitude;
	logic        [glcc_pkg::HDG_W-1:0]     course;

	modport source(output valid, latitude, longitude, course, input ready);
	modport sink(input valid, latitude, longitude, course, output ready);
endinterface

interface glcc_lap_if;
	logic                                  valid;
	logic                                  ready;
	logic        [glcc_pkg::LAPS_W-1:0]    lap_count;
	logic                                  lap_done;
	logic                                  near_home;
	logic signed [glcc_pkg::OUT_POS_W-1:0] local_x;
	logic signed [glcc_pkg::OUT_POS_W-1:0] local_y;

	modport source(output valid, lap_count, lap_done, near_home, local_x, local_y,
		input ready);
	modport sink(input valid, lap_count, lap_done, near_home, local_x, local_y,
		output ready);
endinterface

/* rtl/core/glcc_mac.sv */
// Shared signed multiply-accumulate unit with registered product.
module glcc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [glcc_pkg::MUL_A_W-1:0] a,
	input  logic signed [glcc_pkg::MUL_B_W-1:0] b,
	input  glcc_pkg::mac_op_t                   op,
	output logic signed [glcc_pkg::MUL_P_W-1:0] acc
);

	logic signed [glcc_pkg::MUL_P_W-1:0] prod_s1;
	glcc_pkg::mac_op_t                   op_s1;
	logic signed [glcc_pkg::MUL_P_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= glcc_pkg::MAC_NONE;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op_s1)
			glcc_pkg::MAC_LOAD: acc_q <= prod_s1;
			glcc_pkg::MAC_ADD:  acc_q <= acc_q + prod_s1;
			glcc_pkg::MAC_SUB:  acc_q <= acc_q - prod_s1;
			default:            acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

/* rtl/core/glcc_lap.sv */
// Lap detection: running x average, tolerance checks and lap counter.
module glcc_lap #(
	parameter int POS_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              update,
	input  logic signed [POS_WIDTH-1:0]       x,
	input  logic signed [POS_WIDTH-1:0]       y,
	input  logic        [glcc_pkg::HDG_W-1:0] course_mod,
	input  logic        [glcc_pkg::HDG_W-1:0] home_heading,
	input  logic        [glcc_pkg::TOL_W-1:0] tol,
	output glcc_pkg::lap_res_t                res
);

	logic signed [POS_WIDTH-1:0]        avg_q;
	logic signed [POS_WIDTH-1:0]        last_q;
	logic        [glcc_pkg::LAPS_W-1:0] laps_q;

	logic signed [POS_WIDTH+2:0]        sum;
	logic signed [POS_WIDTH-1:0]        avg_new;
	logic signed [POS_WIDTH:0]          xe;
	logic signed [POS_WIDTH:0]          ye;
	logic        [POS_WIDTH:0]          ax;
	logic        [POS_WIDTH:0]          ay;
	logic        [POS_WIDTH:0]          tol_e;
	logic        [glcc_pkg::HDG_W-1:0]  hh;
	logic        [glcc_pkg::HDG_W-1:0]  hdiff;
	logic                               near;
	logic                               done;

	always_comb begin
		sum = (POS_WIDTH+3)'(avg_q) + (POS_WIDTH+3)'(last_q)
			+ ((POS_WIDTH+3)'(last_q) <<< 1);
		avg_new = sum[POS_WIDTH+1:2];
		xe = (POS_WIDTH+1)'(x);
		ye = (POS_WIDTH+1)'(y);
		ax = xe[POS_WIDTH] ? -xe : xe;
		ay = ye[POS_WIDTH] ? -ye : ye;
		tol_e = (POS_WIDTH+1)'(tol);
		hh = glcc_pkg::heading_mod(home_heading);
		hdiff = (course_mod >= hh) ? course_mod - hh : hh - course_mod;
		near = (ax <= tol_e) && (ay <= tol_e) && (hdiff <= glcc_pkg::HEADING_TOL);
		done = near && !x[POS_WIDTH-1] && (x != '0) && avg_new[POS_WIDTH-1];
		res.lap_count = laps_q + glcc_pkg::LAPS_W'(done);
		res.lap_done = done;
		res.near_home = near;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			last_q <= '0;
			laps_q <= '0;
		end else if (update) begin
			avg_q <= avg_new;
			last_q <= x;
			laps_q <= res.lap_count;
		end
	end

endmodule

/* rtl/core/gps_lap_line_crossing_counter.sv */
// Top level of the GPS lap line crossing counter: registers, sequencer, output stage.
// Each fix steps through the sequencer from acceptance until its result is loaded
// into the output register; the input is ready again in the cycle after that, so
// a new fix is taken only once the previous one has left the sequencer. The steps
// are set by the single 35x18 signed multiplier with a registered product and an
// accumulator, used six times per fix: two scale products for the local
// plane, then four rotation products. A result held in the output register
// blocks the sequencer only at its last step. Configuration writes take effect
// at the next clock edge and must be made while no fix is in progress.
module gps_lap_line_crossing_counter #(
	parameter int POS_WIDTH = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	glcc_fix_if.sink                              fix,
	glcc_lap_if.source                            lap,
	input  logic                                  cfg_wr_en,
	input  logic [glcc_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [glcc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_MX   = 11'b000_0000_0010,
		ST_MY   = 11'b000_0000_0100,
		ST_CAPX = 11'b000_0000_1000,
		ST_CAPY = 11'b000_0001_0000,
		ST_XC   = 11'b000_0010_0000,
		ST_YS   = 11'b000_0100_0000,
		ST_YC   = 11'b000_1000_0000,
		ST_XS   = 11'b001_0000_0000,
		ST_W2   = 11'b010_0000_0000,
		ST_FIN  = 11'b100_0000_0000
	} state_t;

	localparam int RW = glcc_pkg::ROT_W;
	localparam logic signed [RW-1:0] POS_MAX = (RW'(1) <<< (POS_WIDTH-1)) - RW'(1);
	localparam logic signed [RW-1:0] POS_MIN = -POS_MAX - RW'(1);

	state_t state_q;
	state_t state_d;

	logic signed [glcc_pkg::LAT_W-1:0]   home_lat_q;
	logic signed [glcc_pkg::LON_W-1:0]   home_lon_q;
	logic        [glcc_pkg::HDG_W-1:0]   home_hdg_q;
	logic        [glcc_pkg::SCALE_W-1:0] x_scale_q;
	logic        [glcc_pkg::SCALE_W-1:0] y_scale_q;
	logic signed [glcc_pkg::TRIG_W-1:0]  cos_q;
	logic signed [glcc_pkg::TRIG_W-1:0]  sin_q;
	logic        [glcc_pkg::TOL_W-1:0]   tol_q;

	logic signed [glcc_pkg::DLON_W-1:0]  dlon_q;
	logic signed [glcc_pkg::DLAT_W-1:0]  dlat_q;
	logic        [glcc_pkg::HDG_W-1:0]   crs_q;
	logic signed [glcc_pkg::MUL_A_W-1:0] x0_q;
	logic signed [glcc_pkg::MUL_A_W-1:0] y0_q;
	logic signed [POS_WIDTH-1:0]         xr_q;

	logic signed [glcc_pkg::MUL_A_W-1:0] mul_a;
	logic signed [glcc_pkg::MUL_B_W-1:0] mul_b;
	glcc_pkg::mac_op_t                   mac_op;
	logic signed [glcc_pkg::MUL_P_W-1:0] acc;

	logic signed [RW-1:0]                rot;
	logic signed [POS_WIDTH-1:0]         rot_sat;
	logic                                fix_acc;
	logic                                out_load;
	glcc_pkg::lap_res_t                  res;

	logic                                out_valid_q;
	glcc_pkg::lap_res_t                  res_q;
	logic signed [31:0]                  out_x_q;
	logic signed [31:0]                  out_y_q;

	assign fix.ready = (state_q == ST_IDLE);
	assign fix_acc = fix.valid && fix.ready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || lap.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_lat_q <= '0;
			home_lon_q <= '0;
			home_hdg_q <= '0;
			x_scale_q <= glcc_pkg::SCALE_RST;
			y_scale_q <= glcc_pkg::SCALE_RST;
			cos_q <= glcc_pkg::COS_RST;
			sin_q <= '0;
			tol_q <= glcc_pkg::TOL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				glcc_pkg::CFG_HOME_LAT: home_lat_q <= cfg_wdata[glcc_pkg::LAT_W-1:0];
				glcc_pkg::CFG_HOME_LON: home_lon_q <= cfg_wdata[glcc_pkg::LON_W-1:0];
				glcc_pkg::CFG_HOME_HDG: home_hdg_q <= cfg_wdata[glcc_pkg::HDG_W-1:0];
				glcc_pkg::CFG_X_SCALE:  x_scale_q <= cfg_wdata[glcc_pkg::SCALE_W-1:0];
				glcc_pkg::CFG_Y_SCALE:  y_scale_q <= cfg_wdata[glcc_pkg::SCALE_W-1:0];
				glcc_pkg::CFG_COS_HDG:  cos_q <= cfg_wdata[glcc_pkg::TRIG_W-1:0];
				glcc_pkg::CFG_SIN_HDG:  sin_q <= cfg_wdata[glcc_pkg::TRIG_W-1:0];
				glcc_pkg::CFG_POS_TOL:  tol_q <= cfg_wdata[glcc_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		mac_op = glcc_pkg::MAC_NONE;
		unique case (state_q)
			ST_IDLE: if (fix_acc) state_d = ST_MX;
			ST_MX: begin
				mul_a = glcc_pkg::MUL_A_W'(dlon_q);
				mul_b = glcc_pkg::MUL_B_W'($signed({1'b0, x_scale_q}));
				mac_op = glcc_pkg::MAC_LOAD;
				state_d = ST_MY;
			end
			ST_MY: begin
				mul_a = glcc_pkg::MUL_A_W'(dlat_q);
				mul_b = glcc_pkg::MUL_B_W'($signed({1'b0, y_scale_q}));
				mac_op = glcc_pkg::MAC_LOAD;
				state_d = ST_CAPX;
			end
			ST_CAPX: state_d = ST_CAPY;
			ST_CAPY: state_d = ST_XC;
			ST_XC: begin
				mul_a = x0_q;
				mul_b = glcc_pkg::MUL_B_W'(cos_q);
				mac_op = glcc_pkg::MAC_LOAD;
				state_d = ST_YS;
			end
			ST_YS: begin
				mul_a = y0_q;
				mul_b = glcc_pkg::MUL_B_W'(sin_q);
				mac_op = glcc_pkg::MAC_ADD;
				state_d = ST_YC;
			end
			ST_YC: begin
				mul_a = y0_q;
				mul_b = glcc_pkg::MUL_B_W'(cos_q);
				mac_op = glcc_pkg::MAC_LOAD;
				state_d = ST_XS;
			end
			ST_XS: begin
				mul_a = x0_q;
				mul_b = glcc_pkg::MUL_B_W'(sin_q);
				mac_op = glcc_pkg::MAC_SUB;
				state_d = ST_W2;
			end
			ST_W2: state_d = ST_FIN;
			ST_FIN: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	glcc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (mul_a),
		.b      (mul_b),
		.op     (mac_op),
		.acc    (acc)
	);

	always_comb begin
		rot = acc[glcc_pkg::MUL_P_W-1:glcc_pkg::TRIG_SH];
		if (rot > POS_MAX) begin
			rot_sat = POS_WIDTH'(POS_MAX);
		end else if (rot < POS_MIN) begin
			rot_sat = POS_WIDTH'(POS_MIN);
		end else begin
			rot_sat = POS_WIDTH'(rot);
		end
	end

	always_ff @(posedge clk) begin
		if (fix_acc) begin
			dlon_q <= glcc_pkg::DLON_W'(fix.longitude) - glcc_pkg::DLON_W'(home_lon_q);
			dlat_q <= glcc_pkg::DLAT_W'(fix.latitude) - glcc_pkg::DLAT_W'(home_lat_q);
			crs_q <= glcc_pkg::heading_mod(fix.course);
		end
		if (state_q == ST_CAPX) begin
			x0_q <= acc[glcc_pkg::SCALE_SH+glcc_pkg::MUL_A_W-1:glcc_pkg::SCALE_SH];
		end
		if (state_q == ST_CAPY) begin
			y0_q <= acc[glcc_pkg::SCALE_SH+glcc_pkg::MUL_A_W-1:glcc_pkg::SCALE_SH];
		end
		if (state_q == ST_XS) begin
			xr_q <= rot_sat;
		end
	end

	glcc_lap #(
		.POS_WIDTH (POS_WIDTH)
	) u_lap (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (out_load),
		.x            (xr_q),
		.y            (rot_sat),
		.course_mod   (crs_q),
		.home_heading (home_hdg_q),
		.tol          (tol_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (lap.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res;
			out_x_q <= 32'(xr_q);
			out_y_q <= 32'(rot_sat);
		end
	end

	assign lap.valid = out_valid_q;
	assign lap.lap_count = res_q.lap_count;
	assign lap.lap_done = res_q.lap_done;
	assign lap.near_home = res_q.near_home;
	assign lap.local_x = out_x_q[glcc_pkg::OUT_POS_W-1:0];
	assign lap.local_y = out_y_q[glcc_pkg::OUT_POS_W-1:0];

endmodule

/* tb/tb_gps_lap_line_crossing_counter.sv */
`timescale 1ns / 1ps
// Testbench for the GPS lap line crossing counter: stimulus, lap prediction and result checks.
module tb_gps_lap_line_crossing_counter;

	localparam longint POS_MAX = (longint'(1) <<< (glcc_pkg::OUT_POS_W - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;

	typedef struct packed {
		logic [glcc_pkg::LAT_W-1:0] lat;
		logic [glcc_pkg::LON_W-1:0] lon;
		logic [glcc_pkg::HDG_W-1:0] crs;
	} fix_t;

	typedef struct packed {
		logic [glcc_pkg::LAPS_W-1:0]    lap_count;
		logic                           lap_done;
		logic                           near_home;
		logic [glcc_pkg::OUT_POS_W-1:0] local_x;
		logic [glcc_pkg::OUT_POS_W-1:0] local_y;
	} lap_t;

	typedef struct packed {
		logic [glcc_pkg::LAT_W-1:0]   home_lat;
		logic [glcc_pkg::LON_W-1:0]   home_lon;
		logic [glcc_pkg::HDG_W-1:0]   home_hdg;
		logic [glcc_pkg::SCALE_W-1:0] x_scale;
		logic [glcc_pkg::SCALE_W-1:0] y_scale;
		logic [glcc_pkg::TRIG_W-1:0]  cos_hdg;
		logic [glcc_pkg::TRIG_W-1:0]  sin_hdg;
		logic [glcc_pkg::TOL_W-1:0]   pos_tol;
	} home_cfg_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en;
	logic [glcc_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [glcc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	glcc_fix_if fix_ch();
	glcc_lap_if lap_ch();

	gps_lap_line_crossing_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.fix       (fix_ch),
		.lap       (lap_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	home_cfg_t                   home;
	longint                      avg_x;
	longint                      last_x;
	logic [glcc_pkg::LAPS_W-1:0] laps;
	lap_t                        pending_laps[$];
	int                          lap_errors = 0;
	bit                          tx_idle;
	bit                          rx_idle;
	int                          rx_hold = 0;
	lap_t                        got_lap;
	lap_t                        want_lap;

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint clamp_pos(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	function automatic lap_t project_fix(input fix_t f);
		longint dlat, dlon, x0, y0, cs, sn, x, y, hd, tol;
		bit     is_near, is_done;
		lap_t   r;
		dlon = longint'($signed(f.lon)) - longint'($signed(home.home_lon));
		dlat = longint'($signed(f.lat)) - longint'($signed(home.home_lat));
		x0 = (dlon * longint'(home.x_scale)) >>> glcc_pkg::SCALE_SH;
		y0 = (dlat * longint'(home.y_scale)) >>> glcc_pkg::SCALE_SH;
		cs = longint'($signed(home.cos_hdg));
		sn = longint'($signed(home.sin_hdg));
		x = clamp_pos((x0 * cs + y0 * sn) >>> glcc_pkg::TRIG_SH);
		y = clamp_pos((y0 * cs - x0 * sn) >>> glcc_pkg::TRIG_SH);
		hd = longint'(f.crs % glcc_pkg::HEADING_MOD)
			- longint'(home.home_hdg % glcc_pkg::HEADING_MOD);
		tol = longint'(home.pos_tol);
		avg_x = (avg_x + 3 * last_x) >>> 2;
		last_x = x;
		is_near = ((x < 0 ? -x : x) <= tol) && ((y < 0 ? -y : y) <= tol) &&
			((hd < 0 ? -hd : hd) <= longint'(glcc_pkg::HEADING_TOL));
		is_done = is_near && x > 0 && avg_x < 0;
		if (is_done)
			laps = laps + 1'b1;
		r.lap_count = laps;
		r.lap_done = is_done;
		r.near_home = is_near;
		r.local_x = x[glcc_pkg::OUT_POS_W-1:0];
		r.local_y = y[glcc_pkg::OUT_POS_W-1:0];
		return r;
	endfunction

	function automatic fix_t mk_fix(input longint lat, input longint lon, input longint crs);
		fix_t f;
		f.lat = lat[glcc_pkg::LAT_W-1:0];
		f.lon = lon[glcc_pkg::LON_W-1:0];
		f.crs = crs[glcc_pkg::HDG_W-1:0];
		return f;
	endfunction

	function automatic home_cfg_t mk_home(input longint lat, input longint lon,
		input longint hdg, input longint xs, input longint ys, input longint cs,
		input longint sn, input longint tol);
		home_cfg_t c;
		c.home_lat = lat[glcc_pkg::LAT_W-1:0];
		c.home_lon = lon[glcc_pkg::LON_W-1:0];
		c.home_hdg = hdg[glcc_pkg::HDG_W-1:0];
		c.x_scale = xs[glcc_pkg::SCALE_W-1:0];
		c.y_scale = ys[glcc_pkg::SCALE_W-1:0];
		c.cos_hdg = cs[glcc_pkg::TRIG_W-1:0];
		c.sin_hdg = sn[glcc_pkg::TRIG_W-1:0];
		c.pos_tol = tol[glcc_pkg::TOL_W-1:0];
		return c;
	endfunction

	function automatic fix_t random_fix();
		logic [31:0] r_lat, r_lon, r_crs;
		fix_t        f;
		r_lat = $urandom;
		r_lon = $urandom;
		r_crs = $urandom;
		f.lat = r_lat[glcc_pkg::LAT_W-1:0];
		f.lon = r_lon[glcc_pkg::LON_W-1:0];
		f.crs = r_crs[glcc_pkg::HDG_W-1:0];
		return f;
	endfunction

	function automatic logic [glcc_pkg::HDG_W-1:0] near_course();
		int c;
		c = int'(home.home_hdg % glcc_pkg::HEADING_MOD) + int'($urandom_range(0, 7000))
			- 3500;
		if (c < 0)
			c = c + int'(glcc_pkg::HEADING_MOD);
		if (c < 29536 && $urandom_range(0, 3) == 0)
			c = c + int'(glcc_pkg::HEADING_MOD);
		return c[glcc_pkg::HDG_W-1:0];
	endfunction

	function automatic fix_t track_fix(input longint dlat, input longint dlon);
		return mk_fix(longint'($signed(home.home_lat)) + dlat,
			longint'($signed(home.home_lon)) + dlon, longint'(near_course()));
	endfunction

	function automatic int rand_offset(input int reach);
		return int'($urandom_range(0, 2 * reach)) - reach;
	endfunction

	function automatic longint pick_edge(input int width, input bit is_signed);
		longint all_ones;
		all_ones = (longint'(1) <<< width) - 1;
		if (is_signed)
			return $urandom_range(0, 1) ? (all_ones >>> 1) : (longint'(1) <<< (width - 1));
		return $urandom_range(0, 1) ? all_ones : 0;
	endfunction

	function automatic home_cfg_t rand_track_home();
		home_cfg_t c;
		real       rad;
		longint    lat, lon;
		lat = longint'($urandom_range(0, 32'd1800000000)) - 900000000;
		lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
		c.home_lat = lat[glcc_pkg::LAT_W-1:0];
		c.home_lon = lon[glcc_pkg::LON_W-1:0];
		c.home_hdg = glcc_pkg::HDG_W'($urandom_range(0, 35999));
		c.x_scale = glcc_pkg::SCALE_W'($urandom_range(30000, 131071));
		c.y_scale = glcc_pkg::SCALE_W'($urandom_range(30000, 131071));
		rad = real'(c.home_hdg) * 3.14159265358979 / 18000.0;
		c.cos_hdg = 16'($rtoi($floor(16384.0 * $cos(rad) + 0.5)));
		c.sin_hdg = 16'($rtoi($floor(16384.0 * $sin(rad) + 0.5)));
		c.pos_tol = glcc_pkg::TOL_W'($urandom_range(100, 5000));
		return c;
	endfunction

	task automatic send_fix(input fix_t f);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			fix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fix_ch.valid <= 1'b1;
		fix_ch.latitude <= f.lat;
		fix_ch.longitude <= f.lon;
		fix_ch.course <= f.crs;
		do @(posedge clk); while (fix_ch.ready !== 1'b1);
		pending_laps.push_back(project_fix(f));
	endtask

	task automatic drain_laps();
		fix_ch.valid <= 1'b0;
		while (pending_laps.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [glcc_pkg::CFG_IDX_W-1:0] idx, input longint value,
		input int width, input bit junk);
		logic [glcc_pkg::CFG_DATA_W-1:0] mask, data;
		mask = (width >= glcc_pkg::CFG_DATA_W) ? '1 : ((32'h1 << width) - 1);
		data = junk ? $urandom : '0;
		data = (data & ~mask) | (value[glcc_pkg::CFG_DATA_W-1:0] & mask);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic load_home(input home_cfg_t c, input bit junk);
		drain_laps();
		write_reg(glcc_pkg::CFG_HOME_LAT, c.home_lat, glcc_pkg::LAT_W, junk);
		write_reg(glcc_pkg::CFG_HOME_LON, c.home_lon, glcc_pkg::LON_W, junk);
		write_reg(glcc_pkg::CFG_HOME_HDG, c.home_hdg, glcc_pkg::HDG_W, junk);
		write_reg(glcc_pkg::CFG_X_SCALE, c.x_scale, glcc_pkg::SCALE_W, junk);
		write_reg(glcc_pkg::CFG_Y_SCALE, c.y_scale, glcc_pkg::SCALE_W, junk);
		write_reg(glcc_pkg::CFG_COS_HDG, c.cos_hdg, glcc_pkg::TRIG_W, junk);
		write_reg(glcc_pkg::CFG_SIN_HDG, c.sin_hdg, glcc_pkg::TRIG_W, junk);
		write_reg(glcc_pkg::CFG_POS_TOL, c.pos_tol, glcc_pkg::TOL_W, junk);
		cfg_wr_en <= 1'b0;
		home = c;
	endtask

	task automatic set_idling();
		int mode;
		mode = $urandom_range(0, 3);
		tx_idle = mode[0];
		rx_idle = mode[1];
	endtask

	// approach from behind the line, then cross it near home, sometimes followed by a random fix
	task automatic lap_run();
		int reach, dlat, dlon, steps, hop, k, j;
		reach = int'(home.pos_tol) / 8;
		if (reach == 0)
			reach = 1;
		dlat = rand_offset(reach);
		dlon = rand_offset(reach);
		steps = $urandom_range(0, 6);
		hop = $urandom_range(1, 3);
		for (k = steps; k >= 1; k--)
			send_fix(track_fix(-k * hop * dlat, -k * hop * dlon));
		j = $urandom_range(1, 2);
		send_fix(track_fix(j * dlat, j * dlon));
		if ($urandom_range(0, 3) == 0)
			send_fix(random_fix());
	endtask

	task automatic test_reset_defaults();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_fix(mk_fix(0, 0, 0));
		send_fix(mk_fix(0, -400, 100));
		send_fix(mk_fix(0, -200, 36000));
		send_fix(mk_fix(0, 300, 3000));
		send_fix(mk_fix(0, 300, 3001));
		send_fix(mk_fix(0, 0, 65535));
		send_fix(mk_fix(1073741823, 2147483647, 35999));
		send_fix(mk_fix(-1073741824, -2147483648, 0));
		send_fix(mk_fix(900000000, -1800000000, 12345));
		send_fix(mk_fix(-900000000, 1800000000, 0));
		send_fix(mk_fix(718, 0, 0));
		send_fix(mk_fix(719, 0, 0));
		send_fix(mk_fix(720, 0, 0));
	endtask

	task automatic test_config_extremes();
		load_home(mk_home(1073741823, -2147483648, 65535, 131071, 131071, 32767, -32768,
			65535), 1'b1);
		send_fix(mk_fix(-1073741824, 2147483647, 29535));
		send_fix(mk_fix(1073741823, -2147483648, 65535));
		send_fix(mk_fix(1073740823, -2147482648, 26535));
		load_home(mk_home(-1073741824, 2147483647, 35999, 0, 0, -16384, 16384, 0), 1'b0);
		send_fix(mk_fix(-1073741824, 2147483647, 35999));
		send_fix(mk_fix(0, 0, 32999));
		send_fix(mk_fix(5, 5, 32998));
		load_home(mk_home(0, 0, 9000, 72945, 72945, 0, 16384, 65535), 1'b1);
		send_fix(mk_fix(1000, -500, 9000));
		send_fix(mk_fix(-1000, 500, 6000));
		send_fix(mk_fix(0, 0, 12000));
	endtask

	task automatic test_lap_sequences();
		int phase, run;
		for (phase = 0; phase < 30; phase++) begin
			load_home(rand_track_home(), $urandom_range(0, 1));
			set_idling();
			for (run = 0; run < 8; run++) begin
				lap_run();
				if ($urandom_range(0, 15) == 0)
					drain_laps();
			end
		end
	endtask

	task automatic test_random_fixes();
		int        phase, n, sel;
		home_cfg_t c;
		for (phase = 0; phase < 10; phase++) begin
			sel = $urandom_range(0, 2);
			if (sel == 0) begin
				c = mk_home($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			end else if (sel == 1) begin
				c = rand_track_home();
				c.pos_tol = glcc_pkg::TOL_W'($urandom_range(0, 65535));
			end else begin
				c = mk_home(pick_edge(glcc_pkg::LAT_W, 1'b1),
					pick_edge(glcc_pkg::LON_W, 1'b1),
					pick_edge(glcc_pkg::HDG_W, 1'b0), pick_edge(glcc_pkg::SCALE_W, 1'b0),
					pick_edge(glcc_pkg::SCALE_W, 1'b0), pick_edge(glcc_pkg::TRIG_W, 1'b1),
					pick_edge(glcc_pkg::TRIG_W, 1'b1), pick_edge(glcc_pkg::TOL_W, 1'b0));
			end
			load_home(c, $urandom_range(0, 1));
			set_idling();
			for (n = 0; n < 80; n++) begin
				if ($urandom_range(0, 1) == 0)
					send_fix(random_fix());
				else
					send_fix(track_fix(rand_offset(3000), rand_offset(3000)));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && lap_ch.valid === 1'b1 && lap_ch.ready === 1'b1) begin
			got_lap.lap_count = lap_ch.lap_count;
			got_lap.lap_done = lap_ch.lap_done;
			got_lap.near_home = lap_ch.near_home;
			got_lap.local_x = lap_ch.local_x;
			got_lap.local_y = lap_ch.local_y;
			if (pending_laps.size() == 0) begin
				lap_errors++;
				if (lap_errors <= 10)
					$display("unexpected lap result at %0t", $realtime);
			end else begin
				want_lap = pending_laps.pop_front();
				if (got_lap !== want_lap) begin
					lap_errors++;
					if (lap_errors <= 10)
						$display({"lap mismatch at %0t (expected/actual): count %0d/%0d ",
							"done %0b/%0b near %0b/%0b x %0d/%0d y %0d/%0d"}, $realtime,
							want_lap.lap_count, got_lap.lap_count,
							want_lap.lap_done, got_lap.lap_done,
							want_lap.near_home, got_lap.near_home,
							$signed(want_lap.local_x), $signed(got_lap.local_x),
							$signed(want_lap.local_y), $signed(got_lap.local_y));
				end
			end
			rx_hold = rx_idle ? $urandom_range(0, 17) : 0;
		end
		if (rx_hold != 0) begin
			lap_ch.ready <= 1'b0;
			rx_hold--;
		end else begin
			lap_ch.ready <= 1'b1;
		end
	end

	initial begin
		fix_ch.valid = 1'b0;
		fix_ch.latitude = '0;
		fix_ch.longitude = '0;
		fix_ch.course = '0;
		lap_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = glcc_pkg::CFG_HOME_LAT;
		cfg_wdata = '0;
		home = mk_home(0, 0, 0, glcc_pkg::SCALE_RST, glcc_pkg::SCALE_RST, glcc_pkg::COS_RST,
			0, glcc_pkg::TOL_RST);
		avg_x = 0;
		last_x = 0;
		laps = '0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_lap_sequences();
		test_random_fixes();
		drain_laps();
		repeat (16) @(posedge clk);
		if (lap_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
